// ===== rtl/core/assert_macros.svh =====
// assertion helpers, empty for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMP(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("assertion failed");

`define ASSERT_NXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("assertion failed");

`else

`define ASSERT_IMP(name, clk, rstn, ante, cons)

`define ASSERT_NXT(name, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/gpce_pkg.sv =====
`timescale 1ns / 1ps
package gpce_pkg;

	localparam int EVENT_SLOTS = 21;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [4:0] SLOT_X    = 5'd0;
	localparam logic [4:0] SLOT_Y    = 5'd1;
	localparam logic [4:0] SLOT_Z    = 5'd2;
	localparam logic [4:0] SLOT_T    = 5'd3;
	localparam logic [4:0] SLOT_HAT  = 5'd4;
	localparam logic [4:0] SLOT_BTN0 = 5'd5;

	localparam logic [1:0] KIND_AXIS   = 2'd0;
	localparam logic [1:0] KIND_HAT    = 2'd1;
	localparam logic [1:0] KIND_BUTTON = 2'd2;

	localparam logic [1:0] AXIS_Y = 2'd0;
	localparam logic [1:0] AXIS_X = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;
	localparam logic [1:0] AXIS_T = 2'd3;

	localparam logic [3:0] HAT_UP     = 4'd0;
	localparam logic [3:0] HAT_RIGHT  = 4'd2;
	localparam logic [3:0] HAT_DOWN   = 4'd4;
	localparam logic [3:0] HAT_LEFT   = 4'd6;
	localparam logic [3:0] HAT_CENTER = 4'd8;

	typedef struct packed {
		logic [EVENT_SLOTS-1:0] pend;
		logic [11:0]            x_val;
		logic [11:0]            y_val;
		logic [11:0]            z_val;
		logic [11:0]            t_val;
		logic [1:0]             pov_x;
		logic [1:0]             pov_y;
		logic [15:0]            buttons;
	} job_t;

	typedef struct packed {
		logic push;
		logic full;
		logic pop;
		logic valid;
	} qctl_t;

	function automatic logic [11:0] map10(input logic [9:0] v);
		return 12'({1'b0, v, 1'b0}) - 12'd1024;
	endfunction

	// floor(v*2048/255) = 8v + floor(8v/255)
	function automatic logic [11:0] map8(input logic [7:0] v);
		logic [10:0] v8;
		logic [10:0] q;
		v8 = {v, 3'b000};
		q = 11'((12'(v8) + 12'(v8[10:8]) + 12'd1) >> 8);
		return 12'(v8) + 12'(q) - 12'd1024;
	endfunction

endpackage

// ===== rtl/core/gpce_front.sv =====
`timescale 1ns / 1ps
module gpce_front #(
	parameter int BUTTON_COUNT = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [55:0]         s_tdata,
	input  logic                cfg_valid,
	input  logic                cfg_data,
	output gpce_pkg::job_t      job,
	output gpce_pkg::qctl_t     qctl_out,
	input  gpce_pkg::qctl_t     qctl_in
);
	import gpce_pkg::*;

	localparam logic [15:0] BTN_EN = 16'((17'd1 << BUTTON_COUNT) - 17'd1);

	logic        en_q;
	logic [9:0]  prev_x_q;
	logic [9:0]  prev_y_q;
	logic [7:0]  prev_z_q;
	logic [7:0]  prev_t_q;
	logic [3:0]  prev_hat_q;
	logic [15:0] prev_btn_q;

	logic [7:0]  b0, b1, b2;
	logic [9:0]  x, y;
	logic [7:0]  z, t;
	logic [3:0]  hat;
	logic [15:0] buttons;
	logic        hat_dir;
	logic [1:0]  hat_pov_x;
	logic [1:0]  hat_pov_y;
	logic        accept;
	logic [EVENT_SLOTS-1:0] pend;

	assign b0 = s_tdata[7:0];
	assign b1 = s_tdata[15:8];
	assign b2 = s_tdata[23:16];
	assign x = {b1[1:0], b0};
	assign y = {b2[3:0], b1[7:2]};
	assign z = s_tdata[31:24];
	assign t = s_tdata[47:40];
	assign hat = b2[7:4];
	assign buttons = {s_tdata[55:48], s_tdata[39:32]};

	assign s_tready = !qctl_in.full;
	assign accept = s_tvalid && s_tready;

	always_comb begin
		hat_dir = 1'b0;
		hat_pov_x = 2'b00;
		hat_pov_y = 2'b00;
		case (hat)
			HAT_UP: begin
				hat_dir = 1'b1;
				hat_pov_y = 2'b01;
			end
			HAT_RIGHT: begin
				hat_dir = 1'b1;
				hat_pov_x = 2'b01;
			end
			HAT_DOWN: begin
				hat_dir = 1'b1;
				hat_pov_y = 2'b11;
			end
			HAT_LEFT: begin
				hat_dir = 1'b1;
				hat_pov_x = 2'b11;
			end
			HAT_CENTER: begin
				hat_dir = 1'b1;
			end
			default: begin
				hat_dir = 1'b0;
			end
		endcase
	end

	assign pend = {(buttons ^ prev_btn_q) & BTN_EN,
		(hat != prev_hat_q) && hat_dir,
		t != prev_t_q, z != prev_z_q, y != prev_y_q, x != prev_x_q};

	assign job.pend = pend;
	assign job.x_val = map10(x);
	assign job.y_val = map10(y);
	assign job.z_val = map8(z);
	assign job.t_val = map8(t);
	assign job.pov_x = hat_pov_x;
	assign job.pov_y = hat_pov_y;
	assign job.buttons = buttons;

	always_comb begin
		qctl_out = '0;
		qctl_out.push = accept && en_q && (|pend);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_z_q <= '0;
			prev_t_q <= '0;
			prev_hat_q <= HAT_CENTER;
			prev_btn_q <= '0;
		end else begin
			if (cfg_valid) begin
				en_q <= cfg_data;
			end
			if (accept) begin
				prev_btn_q <= buttons;
				if (en_q) begin
					prev_x_q <= x;
					prev_y_q <= y;
					prev_z_q <= z;
					prev_t_q <= t;
					prev_hat_q <= hat;
				end
			end
		end
	end

endmodule

// ===== rtl/core/gpce_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gpce_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  gpce_pkg::job_t  wr_data,
	input  gpce_pkg::qctl_t ctl_in,
	output gpce_pkg::qctl_t ctl_out,
	output gpce_pkg::job_t  rd_data
);
	import gpce_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	job_t                mem [QUEUE_DEPTH];
	job_t                head_q;
	logic [PW-1:0]       wr_ptr_q;
	logic [PW-1:0]       rd_ptr_q;
	logic [PW-1:0]       rd_ptr_nxt;
	logic [PW:0]         count_q;

	always_comb begin
		ctl_out = '0;
		ctl_out.full = (count_q == (PW+1)'(QUEUE_DEPTH));
		ctl_out.valid = (count_q != '0);
	end

	always_comb begin
		rd_ptr_nxt = rd_ptr_q;
		if (ctl_in.pop) begin
			rd_ptr_nxt = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
		end
	end

	assign rd_data = head_q;

	// head word kept registered, bypassed from the write side when it becomes the head
	always_ff @(posedge clk) begin
		if (ctl_in.push) begin
			mem[wr_ptr_q] <= wr_data;
		end
		if (ctl_in.push && (count_q == '0 || (count_q == (PW+1)'(1) && ctl_in.pop))) begin
			head_q <= wr_data;
		end else begin
			head_q <= mem[rd_ptr_nxt];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (ctl_in.push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			rd_ptr_q <= rd_ptr_nxt;
			count_q <= count_q + (PW+1)'(ctl_in.push) - (PW+1)'(ctl_in.pop);
		end
	end

	`ASSERT_IMP(a_no_pop_empty, clk, arst_n, ctl_in.pop, count_q != '0)
	`ASSERT_IMP(a_no_push_full, clk, arst_n, ctl_in.push, !ctl_out.full)
	`ASSERT_NXT(a_count_step, clk, arst_n, ctl_in.push && !ctl_in.pop, count_q == $past(count_q) + 1'b1)

endmodule

// ===== rtl/core/gpce_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gpce_back (
	input  logic            clk,
	input  logic            arst_n,
	input  gpce_pkg::job_t  job_in,
	input  gpce_pkg::qctl_t qctl_in,
	output gpce_pkg::qctl_t qctl_out,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [23:0]     m_tdata,
	output logic [1:0]      m_tuser,
	output logic            m_tlast
);
	import gpce_pkg::*;

	job_t                   job_q;
	logic [EVENT_SLOTS-1:0] pend_q;
	logic [EVENT_SLOTS-1:0] sel_oh;
	logic [EVENT_SLOTS-1:0] rest;
	logic [4:0]             idx;
	logic [3:0]             btn_idx;
	logic                   have_job;
	logic                   emit;
	logic                   last;
	logic                   load;

	logic        valid_q;
	logic [1:0]  kind_q;
	logic [1:0]  axis_num_q;
	logic [11:0] axis_val_q;
	logic [1:0]  pov_x_q;
	logic [1:0]  pov_y_q;
	logic [4:0]  btn_num_q;
	logic        btn_press_q;
	logic        last_q;

	logic [1:0]  kind_d;
	logic [1:0]  axis_num_d;
	logic [11:0] axis_val_d;
	logic [1:0]  pov_x_d;
	logic [1:0]  pov_y_d;
	logic [4:0]  btn_num_d;
	logic        btn_press_d;

	assign have_job = |pend_q;
	assign sel_oh = pend_q & (~pend_q + 1'b1);
	assign rest = pend_q & ~sel_oh;
	assign last = (rest == '0);
	assign emit = have_job && (!valid_q || m_tready);
	assign load = qctl_in.valid && (!have_job || (emit && last));

	always_comb begin
		qctl_out = '0;
		qctl_out.pop = load;
	end

	always_comb begin
		idx = '0;
		for (int i = 0; i < EVENT_SLOTS; i++) begin
			if (sel_oh[i]) begin
				idx = idx | 5'(i);
			end
		end
	end

	assign btn_idx = 4'(idx - SLOT_BTN0);

	always_comb begin
		kind_d = KIND_AXIS;
		axis_num_d = AXIS_Y;
		axis_val_d = '0;
		pov_x_d = '0;
		pov_y_d = '0;
		btn_num_d = '0;
		btn_press_d = 1'b0;
		case (idx)
			SLOT_X: begin
				axis_num_d = AXIS_X;
				axis_val_d = job_q.x_val;
			end
			SLOT_Y: begin
				axis_num_d = AXIS_Y;
				axis_val_d = job_q.y_val;
			end
			SLOT_Z: begin
				axis_num_d = AXIS_Z;
				axis_val_d = job_q.z_val;
			end
			SLOT_T: begin
				axis_num_d = AXIS_T;
				axis_val_d = job_q.t_val;
			end
			SLOT_HAT: begin
				kind_d = KIND_HAT;
				pov_x_d = job_q.pov_x;
				pov_y_d = job_q.pov_y;
			end
			default: begin
				kind_d = KIND_BUTTON;
				btn_num_d = 5'(btn_idx) + 5'd1;
				btn_press_d = job_q.buttons[btn_idx];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= job_in;
		end
		if (emit) begin
			kind_q <= kind_d;
			axis_num_q <= axis_num_d;
			axis_val_q <= axis_val_d;
			pov_x_q <= pov_x_d;
			pov_y_q <= pov_y_d;
			btn_num_q <= btn_num_d;
			btn_press_q <= btn_press_d;
			last_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				pend_q <= job_in.pend;
			end else if (emit) begin
				pend_q <= rest;
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {btn_press_q, btn_num_q, pov_y_q, pov_x_q, axis_val_q, axis_num_q};
	assign m_tuser = kind_q;
	assign m_tlast = last_q;

	`ASSERT_IMP(a_onehot_sel, clk, arst_n, have_job, $onehot(sel_oh))
	`ASSERT_IMP(a_load_idle, clk, arst_n, load, !have_job || (emit && last))
	`ASSERT_NXT(a_emit_valid, clk, arst_n, emit, valid_q)

endmodule

// ===== rtl/core/gamepad_report_change_events.sv =====
`timescale 1ns / 1ps
// channel  dir  handshake            payload
// s        in   s_tvalid/s_tready    s_tdata: report bytes 0..6
// m        out  m_tvalid/m_tready    m_tdata, m_tuser (event kind), m_tlast
// cfg      in   cfg_valid/cfg_ready  cfg_data: events_enabled
//
// one event word leaves per cycle while m_tready is high; a report causes one event
// per change (up to 21), issued in turn by the event sequencer in the back end
// the front takes a report every cycle while the two-entry job queue has room
// reports that cause no event never enter the queue
// reset clears state, queue and output; events_enabled resets to 1
module gamepad_report_change_events #(
	parameter int BUTTON_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // report_byte0 .. report_byte6
	output logic        m_tvalid,
	input  logic        m_tready,
	// axis_number, axis_value, pov_x, pov_y, button_number, button_pressed
	output logic [23:0] m_tdata,
	output logic [1:0]  m_tuser,  // event_kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);
	import gpce_pkg::*;

	job_t  job_push;
	job_t  job_pop;
	qctl_t front_ctl;
	qctl_t queue_ctl;
	qctl_t back_ctl;
	qctl_t queue_in;

	assign cfg_ready = 1'b1;

	always_comb begin
		queue_in = '0;
		queue_in.push = front_ctl.push;
		queue_in.pop = back_ctl.pop;
	end

	gpce_front #(
		.BUTTON_COUNT(BUTTON_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.job      (job_push),
		.qctl_out (front_ctl),
		.qctl_in  (queue_ctl)
	);

	gpce_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_data(job_push),
		.ctl_in (queue_in),
		.ctl_out(queue_ctl),
		.rd_data(job_pop)
	);

	gpce_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job_in  (job_pop),
		.qctl_in (queue_ctl),
		.qctl_out(back_ctl),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule
